// ===== hdl/cnlm_pkg.sv =====
package cnlm_pkg;

	localparam int CFG_BITS   = 11;
	localparam int COORD_BITS = 10;

	localparam logic [CFG_BITS-1:0] SIZE_RESET = CFG_BITS'(20);

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef logic [COORD_BITS-1:0] coord_t;

endpackage

// ===== hdl/cnlm_pixel_if.sv =====
interface cnlm_pixel_if #(
	parameter int SAMPLE_BITS = 16
);
	logic                   valid;
	logic                   ready;
	logic [SAMPLE_BITS-1:0] pixel;

	modport source (output valid, output pixel, input ready);
	modport sink   (input valid, input pixel, output ready);
endinterface

// ===== hdl/cnlm_result_if.sv =====
interface cnlm_result_if;
	import cnlm_pkg::*;

	logic   valid;
	logic   ready;
	logic   is_minimum;
	coord_t centre_row;
	coord_t centre_col;

	modport source (output valid, output is_minimum, output centre_row, output centre_col,
		input ready);
	modport sink   (input valid, input is_minimum, input centre_row, input centre_col,
		output ready);
endinterface

// ===== hdl/cross_neighbour_local_minimum.sv =====
// The pixel that completes a window passes the pixel stage, then the output register.
// One pixel per cycle unless stalled; line stores take one read and one write per cycle.
// A stalled result only holds the pixel stage when that pixel itself produces a result.
// Reset clears the counters, the window, the pipeline valids and sets both sizes to 20.
// The line stores are not cleared; no clearing pass follows reset.
module cross_neighbour_local_minimum #(
	parameter int MAX_WIDTH   = 1024,
	parameter int MAX_HEIGHT  = 1024,
	parameter int SAMPLE_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	cnlm_pixel_if.sink                      pixels,
	cnlm_result_if.source                   results,
	input  logic                            wr_en,
	input  cnlm_pkg::reg_idx_t              wr_index,
	input  logic [cnlm_pkg::CFG_BITS-1:0]   wr_data
);
	import cnlm_pkg::*;

	localparam int CW = $clog2(MAX_WIDTH);
	localparam int RW = $clog2(MAX_HEIGHT);

	logic [CFG_BITS-1:0]    width_q;
	logic [CFG_BITS-1:0]    height_q;
	logic [31:0]            w_lim;
	logic [31:0]            h_lim;

	logic [CW-1:0]          col_q;
	logic [RW-1:0]          row_q;
	logic [CW-1:0]          col_d;
	logic [RW-1:0]          row_d;
	logic [31:0]            col_inc;
	logic [31:0]            row_inc;
	logic [31:0]            row_dec;
	logic [31:0]            col_dec;
	logic                   emit;

	logic [SAMPLE_BITS-1:0] older_mem [MAX_WIDTH];
	logic [SAMPLE_BITS-1:0] newer_mem [MAX_WIDTH];

	logic                   v_s1;
	logic [SAMPLE_BITS-1:0] px_s1;
	logic [CW-1:0]          idx_s1;
	logic                   emit_s1;
	coord_t                 row_s1;
	coord_t                 col_s1;
	logic [SAMPLE_BITS-1:0] old_rd_s1;
	logic [SAMPLE_BITS-1:0] new_rd_s1;
	logic                   fwd_sel_s1;
	logic [SAMPLE_BITS-1:0] fwd_val_s1;
	logic [SAMPLE_BITS-1:0] older_val;

	logic [SAMPLE_BITS-1:0] top2_q;
	logic [SAMPLE_BITS-1:0] mid4_q, mid5_q;
	logic [SAMPLE_BITS-1:0] bot8_q;

	logic                   out_v_q;
	logic                   out_min_q;
	coord_t                 out_row_q;
	coord_t                 out_col_q;

	logic                   in_fire;
	logic                   s1_adv;
	logic                   minimum;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= SIZE_RESET;
			height_q <= SIZE_RESET;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_FRAME_WIDTH:  width_q  <= wr_data;
				REG_FRAME_HEIGHT: height_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0)
			w_lim = 32'd1;
		else if (32'(width_q) > 32'(MAX_WIDTH))
			w_lim = 32'(MAX_WIDTH);
		else
			w_lim = 32'(width_q);
		if (height_q == '0)
			h_lim = 32'd1;
		else if (32'(height_q) > 32'(MAX_HEIGHT))
			h_lim = 32'(MAX_HEIGHT);
		else
			h_lim = 32'(height_q);
	end

	assign s1_adv         = v_s1 && (!emit_s1 || !out_v_q || results.ready);
	assign pixels.ready   = !v_s1 || s1_adv;
	assign in_fire        = pixels.valid && pixels.ready;

	always_comb begin
		col_inc = 32'(col_q) + 32'd1;
		row_inc = 32'(row_q) + 32'd1;
		row_dec = 32'(row_q) - 32'd1;
		col_dec = 32'(col_q) - 32'd1;
		emit    = (32'(row_q) >= 32'd2) && (32'(col_q) >= 32'd2) &&
			(32'(col_q) < w_lim) && (32'(row_q) < h_lim);
		if (col_inc >= w_lim) begin
			col_d = '0;
			row_d = (row_inc >= h_lim) ? '0 : row_inc[RW-1:0];
		end else begin
			col_d = col_inc[CW-1:0];
			row_d = row_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			col_q <= col_d;
			row_q <= row_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			new_rd_s1        <= newer_mem[col_q];
			newer_mem[col_q] <= pixels.pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			old_rd_s1 <= older_mem[col_q];
		if (s1_adv)
			older_mem[idx_s1] <= new_rd_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			v_s1 <= 1'b0;
		else if (in_fire)
			v_s1 <= 1'b1;
		else if (s1_adv)
			v_s1 <= 1'b0;
	end

	// forward the older-store write that lands on the same edge as the read
	always_ff @(posedge clk) begin
		if (in_fire) begin
			px_s1      <= pixels.pixel;
			idx_s1     <= col_q;
			emit_s1    <= emit;
			row_s1     <= row_dec[COORD_BITS-1:0];
			col_s1     <= col_dec[COORD_BITS-1:0];
			fwd_sel_s1 <= v_s1 && (idx_s1 == col_q);
			fwd_val_s1 <= new_rd_s1;
		end
	end

	assign older_val = fwd_sel_s1 ? fwd_val_s1 : old_rd_s1;

	assign minimum = !((mid5_q > top2_q) || (mid5_q > bot8_q) ||
		(mid5_q > mid4_q) || (mid5_q > new_rd_s1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			top2_q <= '0;
			mid4_q <= '0;
			mid5_q <= '0;
			bot8_q <= '0;
		end else if (s1_adv) begin
			top2_q <= older_val;
			mid4_q <= mid5_q;
			mid5_q <= new_rd_s1;
			bot8_q <= px_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_v_q <= 1'b0;
		else if (s1_adv && emit_s1)
			out_v_q <= 1'b1;
		else if (results.ready)
			out_v_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			out_min_q <= minimum;
			out_row_q <= row_s1;
			out_col_q <= col_s1;
		end
	end

	assign results.valid      = out_v_q;
	assign results.is_minimum = out_min_q;
	assign results.centre_row = out_row_q;
	assign results.centre_col = out_col_q;

endmodule
